FILE: rtl/secd_pkg.sv
// Package: shared types and constants for the sprite entry chain decoder.
`timescale 1ns / 1ps
`default_nettype none
package secd_pkg;

  localparam int unsigned XW = 10;

  localparam logic [XW-1:0] X_BORDER    = 10'd32;
  localparam logic [XW-1:0] X_RIGHT_LIM = 10'd352;
  localparam logic [XW-1:0] X_WRAP_MIN  = 10'd528;
  localparam logic [XW-1:0] Y_BASE      = 10'd264;
  localparam logic [XW-1:0] CHAIN_STEP  = 10'd16;
  localparam logic signed [XW-1:0] Y_VIS_LO = 10'sd16;
  localparam logic signed [XW:0]   Y_VIS_HI = 11'sd288;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XPOS,
    ST_YPOS,
    ST_OFFS,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_X,
    OP_Y0,
    OP_OFFS,
    OP_STEP
  } alu_op_t;

  typedef struct packed {
    logic    load_in;
    logic    use_alu;
    alu_op_t op;
    logic    emit;
  } ctrl_t;

  typedef struct packed {
    logic enable;
    logic x_ok;
    logic last;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/secd_ctrl.sv
// Sequencer: steps the shared adder through setup and chain emission.
`timescale 1ns / 1ps
`default_nettype none
module secd_ctrl
  import secd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire status_t status,
  output logic         busy,
  output ctrl_t        ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_XPOS;
      end
      ST_XPOS: begin
        state_next = status.enable ? ST_YPOS : ST_IDLE;
      end
      ST_YPOS: begin
        state_next = status.x_ok ? ST_OFFS : ST_IDLE;
      end
      ST_OFFS: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.last) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy         = (state != ST_IDLE);
    ctrl.load_in = 1'b0;
    ctrl.use_alu = 1'b0;
    ctrl.op      = OP_X;
    ctrl.emit    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ctrl.load_in = start;
      end
      ST_XPOS: begin
        ctrl.use_alu = 1'b1;
        ctrl.op      = OP_X;
      end
      ST_YPOS: begin
        ctrl.use_alu = 1'b1;
        ctrl.op      = OP_Y0;
      end
      ST_OFFS: begin
        ctrl.use_alu = 1'b1;
        ctrl.op      = OP_OFFS;
      end
      ST_EMIT: begin
        ctrl.use_alu = 1'b1;
        ctrl.op      = OP_STEP;
        ctrl.emit    = 1'b1;
      end
      default: begin
        ctrl.load_in = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/sprite_entry_chain_decoder_unit.sv
// Top level: sprite entry chain decoder with one shared add/subtract unit.
// Sequence: accept, then the X, Y and offset setup steps; the first command is
//   registered out after setup, then one per cycle, up to eight per entry.
// Entries are accepted only in idle; the single adder serves one entry at a time.
// Disabled entries leave setup at the X step, off-window ones at Y; no beat.
// Reset (synchronous, active high) returns the sequencer to idle, drops strobe.
`timescale 1ns / 1ps
`default_nettype none
module sprite_entry_chain_decoder_unit
  import secd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  y_low,
  input  wire logic [7:0]  attributes,
  input  wire logic [7:0]  tile_low,
  input  wire logic [7:0]  tile_high,
  input  wire logic [7:0]  palette_byte,
  input  wire logic [7:0]  x_low,
  output logic             strobe,
  output logic [15:0]      tile_number,
  output logic [8:0]       x_pos,
  output logic signed [9:0] y_pos,
  output logic [3:0]       palette,
  output logic             flip_x,
  output logic             flip_y,
  output logic             visible,
  output logic             last
);

  ctrl_t   ctrl;
  status_t status;

  logic [7:0]    ylo_r;
  logic [7:0]    xlo_r;
  logic          enable_r;
  logic          yh_r;
  logic          xh_r;
  logic          fx_r;
  logic          fy_r;
  logic [2:0]    extra_r;
  logic [3:0]    pal_r;
  logic [15:0]   tile;
  logic [2:0]    idx;
  logic [XW-1:0] xr;
  logic [XW-1:0] yr;

  logic [XW-1:0] alu_a;
  logic [XW-1:0] alu_b;
  logic          alu_sub;
  logic [XW-1:0] alu_sum;
  logic          vis_now;

  secd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (ctrl.op)
      OP_X: begin
        alu_a = {1'b0, xh_r, xlo_r};
        alu_b = X_BORDER;
      end
      OP_Y0: begin
        alu_a   = Y_BASE;
        alu_b   = {1'b0, yh_r, ylo_r};
        alu_sub = 1'b1;
      end
      OP_OFFS: begin
        alu_a   = yr;
        alu_b   = fx_r ? {3'b000, extra_r, 4'b0000} : '0;
        alu_sub = 1'b1;
      end
      OP_STEP: begin
        alu_a   = yr;
        alu_b   = CHAIN_STEP;
        alu_sub = ~fx_r;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(XW-1){1'b0}}, alu_sub};

  assign status.enable = enable_r;
  assign status.x_ok   = (xr < X_RIGHT_LIM) || (xr > X_WRAP_MIN);
  assign status.last   = (idx == extra_r);

  assign vis_now = ($signed(yr) > Y_VIS_LO) && ($signed({yr[XW-1], yr}) < Y_VIS_HI);

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      ylo_r    <= y_low;
      xlo_r    <= x_low;
      enable_r <= attributes[0];
      yh_r     <= attributes[1];
      xh_r     <= attributes[2];
      fx_r     <= attributes[3];
      fy_r     <= attributes[4];
      extra_r  <= attributes[7:5];
      pal_r    <= palette_byte[3:0];
      tile     <= {1'b0, tile_high[6:0], tile_low};
      idx      <= '0;
    end else if (ctrl.emit) begin
      tile <= tile + 16'd1;
      idx  <= idx + 3'd1;
    end
    if (ctrl.use_alu) begin
      unique case (ctrl.op)
        OP_X:    xr <= alu_sum;
        OP_Y0:   yr <= {1'b0, alu_sum[8:0]};
        OP_OFFS: yr <= alu_sum;
        OP_STEP: yr <= alu_sum;
        default: yr <= alu_sum;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      tile_number <= tile;
      x_pos       <= xr[8:0];
      y_pos       <= yr;
      palette     <= pal_r;
      flip_x      <= fx_r;
      flip_y      <= fy_r;
      visible     <= vis_now;
      last        <= status.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctrl.emit;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/secd_checker.sv
// Checker: port-level properties of the sprite entry chain decoder, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module secd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic       last,
  input wire logic [8:0] x_pos
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted entry");

  a_chain_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside a chain of beats");

  a_mid_chain_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("idle while a chain is unfinished");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("still busy after the last beat");

  a_x_window: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (x_pos > 9'd16) && (x_pos < 9'd352))
    else $error("beat with X outside the window");

endmodule

bind sprite_entry_chain_decoder_unit secd_checker u_secd_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .last   (last),
  .x_pos  (x_pos)
);
`default_nettype wire

FILE: verif/sprite_draw_checker.sv
// Checker: predicts the tile draw commands of each accepted sprite entry and compares every beat.
`timescale 1ns / 1ps
module sprite_draw_checker
  import secd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [7:0]        y_low,
  input  wire logic [7:0]        attributes,
  input  wire logic [7:0]        tile_low,
  input  wire logic [7:0]        tile_high,
  input  wire logic [7:0]        palette_byte,
  input  wire logic [7:0]        x_low,
  input  wire logic              strobe,
  input  wire logic [15:0]       tile_number,
  input  wire logic [8:0]        x_pos,
  input  wire logic signed [9:0] y_pos,
  input  wire logic [3:0]        palette,
  input  wire logic              flip_x,
  input  wire logic              flip_y,
  input  wire logic              visible,
  input  wire logic              last,
  output int                     fail_count,
  output int                     pending
);

  typedef struct {
    logic [15:0]       tile;
    logic [8:0]        x;
    logic signed [9:0] y;
    logic [3:0]        pal;
    logic              fx;
    logic              fy;
    logic              vis;
    logic              last;
  } draw_cmd_t;

  draw_cmd_t draw_queue[$];
  int        mismatches = 0;

  task automatic decode_entry(input logic [7:0] ylo, input logic [7:0] attr,
                              input logic [7:0] tlo, input logic [7:0] thi,
                              input logic [7:0] palb, input logic [7:0] xlo);
    int          xs;
    int          ys;
    int          step;
    int          extra;
    logic [14:0] base;
    draw_cmd_t   cmd;
    if (!attr[0]) return;
    xs = int'({attr[2], xlo}) + int'(X_BORDER);
    if (xs > int'(X_RIGHT_LIM)) xs -= 512;
    if (xs <= 16 || xs >= int'(X_RIGHT_LIM)) return;
    ys = (int'(Y_BASE) - int'({attr[1], ylo})) & 'h1FF;
    base = {thi[6:0], tlo};
    extra = int'(attr[7:5]);
    if (attr[3]) begin
      ys -= extra * int'(CHAIN_STEP);
      step = int'(CHAIN_STEP);
    end else begin
      step = -int'(CHAIN_STEP);
    end
    for (int i = 0; i <= extra; i++) begin
      cmd.tile = 16'(base) + 16'(i);
      cmd.x    = 9'(xs);
      cmd.y    = 10'(ys);
      cmd.pal  = palb[3:0];
      cmd.fx   = attr[3];
      cmd.fy   = attr[4];
      cmd.vis  = (ys > int'(Y_VIS_LO)) && (ys < int'(Y_VIS_HI));
      cmd.last = (i == extra);
      draw_queue.push_back(cmd);
      ys += step;
    end
  endtask

  always @(posedge clk) begin
    draw_cmd_t want;
    if (!rst) begin
      if (strobe) begin
        if (draw_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected draw beat: tile %0d x %0d y %0d pal %0d fx %b fy %b vis %b last %b",
                     $time, tile_number, x_pos, y_pos, palette, flip_x, flip_y, visible, last);
        end else begin
          want = draw_queue.pop_front();
          if (want.tile !== tile_number || want.x !== x_pos || want.y !== y_pos ||
              want.pal !== palette || want.fx !== flip_x || want.fy !== flip_y ||
              want.vis !== visible || want.last !== last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: draw beat mismatch", $time);
              $display("  expected tile %0d x %0d y %0d pal %0d fx %b fy %b vis %b last %b",
                       want.tile, want.x, want.y, want.pal, want.fx, want.fy, want.vis,
                       want.last);
              $display("  actual   tile %0d x %0d y %0d pal %0d fx %b fy %b vis %b last %b",
                       tile_number, x_pos, y_pos, palette, flip_x, flip_y, visible, last);
            end
          end
        end
      end
      if (start && !busy)
        decode_entry(y_low, attributes, tile_low, tile_high, palette_byte, x_low);
    end
    fail_count <= mismatches;
    pending    <= draw_queue.size();
  end

endmodule

FILE: verif/sprite_entry_chain_decoder_unit_tb.sv
// Testbench top: drives sprite entries into the chain decoder and reports the verdict.
`timescale 1ns / 1ps
module sprite_entry_chain_decoder_unit_tb;
  import secd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 107;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic [7:0]        y_low;
  logic [7:0]        attributes;
  logic [7:0]        tile_low;
  logic [7:0]        tile_high;
  logic [7:0]        palette_byte;
  logic [7:0]        x_low;
  logic              strobe;
  logic [15:0]       tile_number;
  logic [8:0]        x_pos;
  logic signed [9:0] y_pos;
  logic [3:0]        palette;
  logic              flip_x;
  logic              flip_y;
  logic              visible;
  logic              last;

  int fail_count;
  int pending;
  int idle_pct;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  sprite_entry_chain_decoder_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .y_low(y_low), .attributes(attributes), .tile_low(tile_low),
    .tile_high(tile_high), .palette_byte(palette_byte), .x_low(x_low),
    .strobe(strobe), .tile_number(tile_number), .x_pos(x_pos), .y_pos(y_pos),
    .palette(palette), .flip_x(flip_x), .flip_y(flip_y), .visible(visible),
    .last(last)
  );

  sprite_draw_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .y_low(y_low), .attributes(attributes), .tile_low(tile_low),
    .tile_high(tile_high), .palette_byte(palette_byte), .x_low(x_low),
    .strobe(strobe), .tile_number(tile_number), .x_pos(x_pos), .y_pos(y_pos),
    .palette(palette), .flip_x(flip_x), .flip_y(flip_y), .visible(visible),
    .last(last), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pack_attr(input int chain, input int flip, input bit xh,
                                           input bit yh, input bit en);
    return {3'(chain), 2'(flip), xh, yh, en};
  endfunction

  task automatic send_entry(input logic [7:0] ylo, input logic [7:0] attr,
                            input logic [7:0] tlo, input logic [7:0] thi,
                            input logic [7:0] palb, input logic [7:0] xlo);
    while ($urandom_range(99, 0) < idle_pct) begin
      start        <= 1'b0;
      y_low        <= 8'($urandom);
      attributes   <= 8'($urandom);
      tile_low     <= 8'($urandom);
      tile_high    <= 8'($urandom);
      palette_byte <= 8'($urandom);
      x_low        <= 8'($urandom);
      @(posedge clk);
    end
    start        <= 1'b1;
    y_low        <= ylo;
    attributes   <= attr;
    tile_low     <= tlo;
    tile_high    <= thi;
    palette_byte <= palb;
    x_low        <= xlo;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_random_phase(input int pct);
    logic [7:0] attr;
    idle_pct = pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      attr    = 8'($urandom);
      attr[0] = ($urandom_range(9, 0) != 0);
      send_entry(8'($urandom), attr, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    y_low        = '0;
    attributes   = '0;
    tile_low     = '0;
    tile_high    = '0;
    palette_byte = '0;
    x_low        = '0;
    idle_pct     = 23;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled entry, then the horizontal window edges
    send_entry(8'h10, pack_attr(7, 0, 0, 0, 0), 8'h12, 8'h34, 8'h05, 8'h40);
    send_entry(8'h00, pack_attr(0, 0, 0, 0, 1), 8'h00, 8'h00, 8'h00, 8'h00);
    send_entry(8'hFF, pack_attr(7, 1, 1, 1, 1), 8'hFF, 8'hFF, 8'hFF, 8'd63);
    send_entry(8'h20, pack_attr(1, 0, 1, 0, 1), 8'h01, 8'h00, 8'h03, 8'd64);
    send_entry(8'h20, pack_attr(1, 0, 1, 0, 1), 8'h01, 8'h00, 8'h03, 8'd65);
    send_entry(8'h20, pack_attr(1, 0, 1, 0, 1), 8'h01, 8'h00, 8'h03, 8'd240);
    send_entry(8'h30, pack_attr(3, 2, 1, 0, 1), 8'hAA, 8'h55, 8'hF0, 8'd241);
    send_entry(8'h40, pack_attr(7, 3, 1, 1, 1), 8'h55, 8'hAA, 8'h0F, 8'd255);
    send_entry(8'h50, pack_attr(2, 0, 0, 0, 1), 8'h80, 8'h80, 8'hA5, 8'd255);
    // vertical window edges and chains crossing them
    send_entry(8'd248, pack_attr(0, 0, 0, 0, 1), 8'h11, 8'h22, 8'h01, 8'd100);
    send_entry(8'd247, pack_attr(0, 0, 0, 0, 1), 8'h11, 8'h22, 8'h02, 8'd100);
    send_entry(8'd232, pack_attr(0, 2, 0, 1, 1), 8'h33, 8'h44, 8'h03, 8'd100);
    send_entry(8'd233, pack_attr(0, 2, 0, 1, 1), 8'h33, 8'h44, 8'h04, 8'd100);
    send_entry(8'd247, pack_attr(7, 0, 0, 0, 1), 8'h01, 8'h02, 8'h05, 8'd10);
    send_entry(8'd9,   pack_attr(7, 1, 0, 1, 1), 8'hFE, 8'h7F, 8'h06, 8'd20);
    send_entry(8'd8,   pack_attr(7, 2, 0, 0, 1), 8'h00, 8'h00, 8'h07, 8'd30);
    send_entry(8'd8,   pack_attr(5, 3, 1, 0, 1), 8'hF8, 8'h7F, 8'h08, 8'd0);
    send_entry(8'd0,   pack_attr(4, 1, 0, 1, 1), 8'h7F, 8'h01, 8'hFF, 8'd128);
    wait_drained();

    send_random_phase(23);
    send_random_phase(45);
    send_random_phase(0);

    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sprite_entry_chain_decoder_unit.f
rtl/secd_pkg.sv
rtl/secd_ctrl.sv
rtl/sprite_entry_chain_decoder_unit.sv
rtl/secd_checker.sv
verif/sprite_draw_checker.sv
verif/sprite_entry_chain_decoder_unit_tb.sv
